>>> design/heightfield_min_downsample_core_macros.svh
// Assertion macros for the heightfield min downsample core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HEIGHTFIELD_MIN_DOWNSAMPLE_CORE_MACROS_SVH
`define HEIGHTFIELD_MIN_DOWNSAMPLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked on clk, masked while rst is high
`define HMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on clk at every edge, reset included
`define HMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMD_ASSERT(lbl, prop, msg)
`define HMD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/hmd_pkg.sv
// Shared constants, types and helpers for the heightfield min downsample core.
// No dependencies; used by hmd_build_seq and heightfield_min_downsample_core.
`default_nettype none

package hmd_pkg;

  localparam int MAX_SIDE      = 65;
  localparam int QUAD_SIDE     = MAX_SIDE - 1;
  localparam int SIDE_W        = 7;
  localparam int LOD_W         = 4;
  localparam int HEIGHT_W      = 32;
  localparam int SAMPLE_DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int SAMPLE_ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int QUAD_DEPTH    = QUAD_SIDE * QUAD_SIDE;
  localparam int QUAD_ADDR_W   = $clog2(QUAD_DEPTH);
  localparam int QUAD_IDX_W    = $clog2(QUAD_SIDE);

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_LOD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIDE = 2'd1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd65;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // build walker -> datapath
  typedef struct packed {
    logic                     issue;   // sample read issued this cycle
    logic                     first;   // first sample of a quad
    logic                     last;    // last sample of a quad
    logic                     done;    // last sample of the whole build
    logic [SAMPLE_ADDR_W-1:0] saddr;
    logic [QUAD_ADDR_W-1:0]   qaddr;
  } bseq_t;

  function automatic logic [SAMPLE_ADDR_W-1:0] sample_addr(
      input logic [SIDE_W-1:0] row, input logic [SIDE_W-1:0] col);
    return SAMPLE_ADDR_W'(row) * SAMPLE_ADDR_W'(MAX_SIDE) + SAMPLE_ADDR_W'(col);
  endfunction

  function automatic logic [QUAD_ADDR_W-1:0] quad_addr(
      input logic [QUAD_IDX_W-1:0] qrow, input logic [QUAD_IDX_W-1:0] qcol);
    return QUAD_ADDR_W'(qrow) * QUAD_ADDR_W'(QUAD_SIDE) + QUAD_ADDR_W'(qcol);
  endfunction

  // a + b, clipped to lim
  function automatic logic [SIDE_W-1:0] clip_add(
      input logic [SIDE_W-1:0] a, input logic [SIDE_W-1:0] b,
      input logic [SIDE_W-1:0] lim);
    logic [SIDE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, lim}) ? lim : s[SIDE_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/hmd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hmd_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/hmd_build_seq.sv
// Build walker: steps through every coarse quad and every fine sample in it,
// one sample read per cycle. Depends on hmd_pkg and the macros header.
`default_nettype none
`include "heightfield_min_downsample_core_macros.svh"

module hmd_build_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hmd_pkg::SIDE_W-1:0] nm1,   // last fine index, n - 1
  input  logic [hmd_pkg::SIDE_W-1:0] step,
  output hmd_pkg::bseq_t            bs
);

  logic                          active;
  logic [hmd_pkg::SIDE_W-1:0]    fi, fj, si, sj, ei, ej;
  logic [hmd_pkg::SIDE_W-1:0]    nm1_r, step_r;
  logic [hmd_pkg::QUAD_IDX_W-1:0] qi, qj;
  logic                          col_end, row_end, quad_end_x, quad_end_y;

  always_comb begin
    col_end    = (fi == ei);
    row_end    = (fj == ej);
    quad_end_x = (ei == nm1_r);
    quad_end_y = (ej == nm1_r);
    bs.issue   = active;
    bs.first   = (fi == si) && (fj == sj);
    bs.last    = col_end && row_end;
    bs.done    = col_end && row_end && quad_end_x && quad_end_y;
    bs.saddr   = hmd_pkg::sample_addr(fj, fi);
    bs.qaddr   = hmd_pkg::quad_addr(qj, qi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      nm1_r  <= nm1;
      step_r <= step;
      fi     <= '0;
      fj     <= '0;
      si     <= '0;
      sj     <= '0;
      ei     <= hmd_pkg::clip_add('0, step, nm1);
      ej     <= hmd_pkg::clip_add('0, step, nm1);
      qi     <= '0;
      qj     <= '0;
    end else if (active) begin
      if (!col_end) begin
        fi <= fi + 1'b1;
      end else if (!row_end) begin
        fi <= si;
        fj <= fj + 1'b1;
      end else if (!quad_end_x) begin
        // next quad in this band; its start is the shared edge
        si <= ei;
        fi <= ei;
        fj <= sj;
        ei <= hmd_pkg::clip_add(ei, step_r, nm1_r);
        qi <= qi + 1'b1;
      end else if (!quad_end_y) begin
        sj <= ej;
        fj <= ej;
        si <= '0;
        fi <= '0;
        ei <= hmd_pkg::clip_add('0, step_r, nm1_r);
        ej <= hmd_pkg::clip_add(ej, step_r, nm1_r);
        qi <= '0;
        qj <= qj + 1'b1;
      end else begin
        active <= 1'b0;
      end
    end
  end

  `HMD_ASSERT(a_walk_in_quad,
              active |-> (fi >= si && fi <= ei && fj >= sj && fj <= ej),
              "build walker left its quad")
  `HMD_ASSERT(a_quad_in_grid, active |-> (ei <= nm1_r && ej <= nm1_r),
              "quad range beyond the grid edge")
  `HMD_ASSERT(a_done_stops, (active && bs.done) |=> !active,
              "walker kept issuing after the last sample")
  `HMD_ASSERT(a_start_runs, start |=> active, "walker did not start")

endmodule

`default_nettype wire

>>> design/heightfield_min_downsample_core.sv
// Heightfield min downsample core: top level with control, accumulator and ports.
// Depends on hmd_pkg, hmd_ram, hmd_build_seq and the macros header.
//
// Usage:
//  - s_axis carries one command per transfer, selected by s_axis_tuser:
//    load writes one fine height sample, build computes quad minima for the
//    current lod_level / samples_per_side, query returns the minimum over the
//    quads touching one coarse vertex. Code 3 is dropped silently.
//  - Loads give no result and are taken one per cycle while the block is
//    idle. Build and query give one result on m_axis each.
//  - Query: four quad memory reads, then one drain and one output state.
//    Build: one fine sample read per cycle over all quads (shared edges
//    read twice), then the drain and output states; the single read port
//    of the sample memory sets this pace.
//  - The input side is held (s_axis_tready low) while a build or query runs.
//  - A finished result sits in the m_axis output register; loads keep flowing
//    while it waits. A further result waits in its last state until the
//    output register has been taken.
//  - cfg writes (always ready) must only come while the block is idle.
//    Changing lod_level clears the coarse count.
//  - Reset: rst, synchronous, active high. Registers return to lod_level 0,
//    samples_per_side 65, coarse count 0. Memory contents are not cleared;
//    samples must be loaded before a build reads them.
`default_nettype none
`include "heightfield_min_downsample_core_macros.svh"

module heightfield_min_downsample_core (
  input  logic                           clk,
  input  logic                           rst,
  // command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // column[6:0], row[13:7], height[45:14]
  input  logic [1:0]                     s_axis_tuser,  // operation[1:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // min_height[31:0], coarse_side[38:32]
  output logic                           m_axis_tuser,  // valid_res[0]
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BUILD  = 5'b00010,
    ST_QUERY  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration and persistent state
  logic [hmd_pkg::LOD_W-1:0]  lod_level;
  logic [hmd_pkg::SIDE_W-1:0] samples_per_side;
  logic [hmd_pkg::SIDE_W-1:0] coarse_count;

  // input unpack
  hmd_pkg::op_t                   in_op;
  logic [hmd_pkg::SIDE_W-1:0]     in_col, in_row;
  logic [hmd_pkg::HEIGHT_W-1:0]   in_height;
  logic                           in_xfer;

  // grid geometry
  logic [hmd_pkg::SIDE_W-1:0] side_n, side_nm1, shifted, cps, step;
  logic                       cps_ok;

  // per-command registers
  logic [hmd_pkg::SIDE_W-1:0] q_col, q_row, pend_cc;
  logic                       res_flag;
  logic [1:0]                 k;

  // query candidate
  logic [hmd_pkg::SIDE_W:0]        t_col, t_row;
  logic                            cand;
  logic [hmd_pkg::QUAD_ADDR_W-1:0] q_raddr;

  // walker
  hmd_pkg::bseq_t bs;
  logic           seq_start;

  // memory ports
  logic                              samp_we, quad_we;
  logic [hmd_pkg::SAMPLE_ADDR_W-1:0] samp_waddr;
  logic [hmd_pkg::HEIGHT_W-1:0]      samp_rdata, quad_rdata, quad_wdata;
  logic [hmd_pkg::QUAD_ADDR_W-1:0]   quad_waddr;

  // read return pipeline and min accumulator
  logic                            rd_valid, rd_first, rd_last, rd_build;
  logic [hmd_pkg::QUAD_ADDR_W-1:0] rd_qaddr;
  logic [hmd_pkg::HEIGHT_W-1:0]    acc, rd_data, acc_new;
  logic                            acc_have;

  logic out_load;

  assign in_op     = hmd_pkg::op_t'(s_axis_tuser);
  assign in_col    = s_axis_tdata[6:0];
  assign in_row    = s_axis_tdata[13:7];
  assign in_height = s_axis_tdata[45:14];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // n = min(samples_per_side, MAX_SIDE); coarse count = (n-1) >> lod + 1
  always_comb begin
    side_n   = (samples_per_side > hmd_pkg::SIDE_W'(hmd_pkg::MAX_SIDE))
               ? hmd_pkg::SIDE_W'(hmd_pkg::MAX_SIDE) : samples_per_side;
    side_nm1 = side_n - 1'b1;
    shifted  = side_nm1 >> lod_level;
    cps      = shifted + 1'b1;
    cps_ok   = (side_n >= 7'd2) && (shifted != '0);
    step     = hmd_pkg::SIDE_W'(1) << lod_level;  // only used when cps_ok
  end

  // quad touching the queried vertex for corner k = {dj, di}
  always_comb begin
    t_col   = {1'b0, q_col} + {{hmd_pkg::SIDE_W{1'b0}}, k[0]};
    t_row   = {1'b0, q_row} + {{hmd_pkg::SIDE_W{1'b0}}, k[1]};
    cand    = (t_col != '0) && (t_row != '0) &&
              (t_col < {1'b0, coarse_count}) && (t_row < {1'b0, coarse_count});
    q_raddr = hmd_pkg::quad_addr(hmd_pkg::QUAD_IDX_W'(t_row - 1'b1),
                                 hmd_pkg::QUAD_IDX_W'(t_col - 1'b1));
  end

  // loads go straight to the sample memory, out-of-grid writes dropped
  assign samp_we    = in_xfer && (in_op == hmd_pkg::OP_LOAD) &&
                      (in_col < side_n) && (in_row < side_n);
  assign samp_waddr = hmd_pkg::sample_addr(in_row, in_col);
  assign seq_start  = in_xfer && (in_op == hmd_pkg::OP_BUILD) && cps_ok;

  hmd_ram #(
    .DEPTH (hmd_pkg::SAMPLE_DEPTH),
    .WIDTH (hmd_pkg::HEIGHT_W),
    .ADDR_W(hmd_pkg::SAMPLE_ADDR_W)
  ) u_sample_mem (
    .clk  (clk),
    .we   (samp_we),
    .waddr(samp_waddr),
    .wdata(in_height),
    .raddr(bs.saddr),
    .rdata(samp_rdata)
  );

  hmd_ram #(
    .DEPTH (hmd_pkg::QUAD_DEPTH),
    .WIDTH (hmd_pkg::HEIGHT_W),
    .ADDR_W(hmd_pkg::QUAD_ADDR_W)
  ) u_quad_mem (
    .clk  (clk),
    .we   (quad_we),
    .waddr(quad_waddr),
    .wdata(quad_wdata),
    .raddr(q_raddr),
    .rdata(quad_rdata)
  );

  hmd_build_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(seq_start),
    .nm1  (side_nm1),
    .step (step),
    .bs   (bs)
  );

  // running signed minimum; a quad restarts on its first sample
  always_comb begin
    rd_data    = rd_build ? samp_rdata : quad_rdata;
    acc_new    = (rd_first || !acc_have || ($signed(rd_data) < $signed(acc))) ? rd_data : acc;
    quad_we    = rd_valid && rd_build && rd_last;
    quad_waddr = rd_qaddr;
    quad_wdata = acc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= bs.issue || ((state == ST_QUERY) && cand);
    end
    rd_build <= bs.issue;
    rd_first <= bs.issue && bs.first;
    rd_last  <= bs.issue && bs.last;
    rd_qaddr <= bs.qaddr;
    if (in_xfer) begin
      acc_have <= 1'b0;
    end else if (rd_valid) begin
      acc      <= acc_new;
      acc_have <= 1'b1;
    end
  end

  // command control
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == hmd_pkg::OP_BUILD) begin
            state_next = cps_ok ? ST_BUILD : ST_FINISH;
          end else if (in_op == hmd_pkg::OP_QUERY) begin
            state_next = ((coarse_count >= 7'd2) && (in_col < coarse_count) &&
                          (in_row < coarse_count)) ? ST_QUERY : ST_FINISH;
          end
        end
      end
      ST_BUILD: begin
        if (bs.done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_QUERY: begin
        if (k == 2'd3) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      lod_level        <= '0;
      samples_per_side <= hmd_pkg::SIDE_RESET;
      coarse_count     <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hmd_pkg::REG_LOD: begin
            if (cfg_data[hmd_pkg::LOD_W-1:0] != lod_level) begin
              coarse_count <= '0;
            end
            lod_level <= cfg_data[hmd_pkg::LOD_W-1:0];
          end
          hmd_pkg::REG_SIDE: begin
            samples_per_side <= cfg_data[hmd_pkg::SIDE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        coarse_count  <= pend_cc;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // per-command context and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_col <= in_col;
      q_row <= in_row;
      k     <= '0;
      if (in_op == hmd_pkg::OP_BUILD) begin
        pend_cc  <= cps_ok ? cps : '0;
        res_flag <= 1'b0;
      end else begin
        pend_cc  <= coarse_count;
        res_flag <= (coarse_count >= 7'd2) && (in_col < coarse_count) &&
                    (in_row < coarse_count);
      end
    end else if (state == ST_QUERY) begin
      k <= k + 1'b1;
    end
    if (out_load) begin
      m_axis_tdata <= {1'b0, pend_cc, res_flag ? acc : '0};
      m_axis_tuser <= res_flag;
    end
  end

  `HMD_ASSERT(a_quad_write_in_build,
              quad_we |-> (state == ST_BUILD || state == ST_DRAIN),
              "quad minimum written outside a build")
  `HMD_ASSERT(a_walk_in_build, bs.issue |-> (state == ST_BUILD),
              "sample walk running outside a build")
  `HMD_ASSERT(a_side_not_one, m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'd1),
              "coarse side of one reported")
  `HMD_ASSERT(a_valid_needs_mesh, (m_axis_tvalid && m_axis_tuser) |->
              (m_axis_tdata[38:32] >= 7'd2),
              "valid query result without a coarse mesh")
  `HMD_ASSERT(a_finish_has_acc,
              (state == ST_FINISH && res_flag) |-> acc_have,
              "valid query finished without any quad read")

endmodule

`default_nettype wire
